// File: design/osmd_pkg.sv
// Shared types and constants for the obstacle-stop motor drive core.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none

package osmd_pkg;

   // Speed limits in percent.
   localparam logic signed [7:0] SPEED_MAX = 8'sd100;
   localparam logic signed [7:0] SPEED_MIN = -8'sd100;
   localparam logic signed [7:0] SPEED_ZERO = 8'sd0;

   // Configuration register indexes.
   localparam logic [2:0] REG_DETECT_DISTANCE = 3'd0;
   localparam logic [2:0] REG_CLEAR_DISTANCE = 3'd1;
   localparam logic [2:0] REG_BRAKE_HOLD_MS = 3'd2;
   localparam logic [2:0] REG_REPORT_STEP = 3'd3;
   localparam logic [2:0] REG_CONFIRM_MS = 3'd4;
   localparam logic [2:0] REG_BRAKE_PAUSE_MS = 3'd5;

   // Configuration reset values.
   localparam logic [8:0] RST_DETECT_DISTANCE = 9'd160;
   localparam logic [8:0] RST_CLEAR_DISTANCE = 9'd176;
   localparam logic [9:0] RST_BRAKE_HOLD_MS = 10'd200;
   localparam logic [8:0] RST_REPORT_STEP = 9'd16;
   localparam logic [15:0] RST_CONFIRM_MS = 16'd100;
   localparam logic [15:0] RST_BRAKE_PAUSE_MS = 16'd1000;

   // Most results one tick can cause.
   localparam int unsigned MAX_ENTRIES = 3;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_SPEED  = 2'd0,
      KIND_DIST   = 2'd1,
      KIND_DETECT = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   // One result of a tick, before the drive levels are worked out.
   typedef struct packed {
      kind_type          kind;
      logic signed [7:0] speed;
      logic              hold;
   } entry_type;

   // Everything the back part needs to emit the results of one tick.
   typedef struct packed {
      entry_type [MAX_ENTRIES-1:0] entries;
      logic [1:0]                  count;
      logic signed [7:0]           target;
      logic [9:0]                  hold_ms;
      logic [8:0]                  distance;
      logic [15:0]                 near_time;
   } plan_type;

   function automatic entry_type make_entry(input kind_type kind,
                                            input logic signed [7:0] speed,
                                            input logic hold);
      entry_type e;
      e.kind = kind;
      e.speed = speed;
      e.hold = hold;
      return e;
   endfunction

endpackage

`default_nettype wire

// File: design/osmd_front.sv
// Front part: configuration registers, controller state and tick classification.
// Turns each accepted tick into a plan of up to three results; uses osmd_pkg.
`default_nettype none

module osmd_front
   import osmd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [9:0]        delta_ms,
   input  wire logic [8:0]        distance,
   input  wire logic signed [7:0] target_speed,
   input  wire logic              csr_write_en,
   input  wire logic [2:0]        csr_index,
   input  wire logic [15:0]       csr_wdata,
   output logic                   plan_push,
   output plan_type               plan
);

   logic [8:0]  detect_ff, clear_ff, step_ff;
   logic [9:0]  brake_hold_ff;
   logic [15:0] confirm_ff, pause_ff;

   logic signed [7:0] speed_ff, speed_in;
   logic              held_ff, held_in;
   logic [15:0]       accum_ff, accum_in;
   logic [8:0]        rep_ff, rep_in;
   logic [15:0]       since_ff, since_in;

   logic signed [7:0] tgt;
   logic [16:0]       since_wide, accum_wide;
   logic [15:0]       since_sum, accum_sum;
   logic [8:0]        thr, diff;
   logic              near, rep_hit;
   logic [1:0]        cnt;

   // Configuration writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         detect_ff <= RST_DETECT_DISTANCE;
         clear_ff <= RST_CLEAR_DISTANCE;
         brake_hold_ff <= RST_BRAKE_HOLD_MS;
         step_ff <= RST_REPORT_STEP;
         confirm_ff <= RST_CONFIRM_MS;
         pause_ff <= RST_BRAKE_PAUSE_MS;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_DETECT_DISTANCE: detect_ff <= csr_wdata[8:0];
            REG_CLEAR_DISTANCE:  clear_ff <= csr_wdata[8:0];
            REG_BRAKE_HOLD_MS:   brake_hold_ff <= csr_wdata[9:0];
            REG_REPORT_STEP:     step_ff <= csr_wdata[8:0];
            REG_CONFIRM_MS:      confirm_ff <= csr_wdata;
            REG_BRAKE_PAUSE_MS:  pause_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp the target and form the saturating timer sums.
   always_comb begin
      if (target_speed > SPEED_MAX) begin
         tgt = SPEED_MAX;
      end else if (target_speed < SPEED_MIN) begin
         tgt = SPEED_MIN;
      end else begin
         tgt = target_speed;
      end
      since_wide = {1'b0, since_ff} + 17'(delta_ms);
      since_sum = since_wide[16] ? 16'hFFFF : since_wide[15:0];
      accum_wide = {1'b0, accum_ff} + 17'(delta_ms);
      accum_sum = accum_wide[16] ? 16'hFFFF : accum_wide[15:0];
      thr = held_ff ? clear_ff : detect_ff;
      near = distance < thr;
      diff = (distance >= rep_ff) ? distance - rep_ff : rep_ff - distance;
      rep_hit = held_ff && (diff >= step_ff);
   end

   // Classify the tick: next state and the list of results it causes.
   always_comb begin
      speed_in = speed_ff;
      held_in = held_ff;
      accum_in = accum_ff;
      rep_in = rep_ff;
      since_in = since_sum;
      cnt = 2'd0;
      plan = '0;
      plan.target = tgt;
      plan.hold_ms = brake_hold_ff;
      plan.distance = distance;

      if (held_ff) begin
         // Obstacle held: report moves, then check whether it has gone.
         if (rep_hit) begin
            plan.entries[cnt] = make_entry(KIND_DIST, speed_ff, 1'b0);
            cnt = cnt + 2'd1;
            rep_in = distance;
         end
         if (near) begin
            accum_in = accum_sum;
         end else begin
            if (speed_ff != tgt) begin
               plan.entries[cnt] = make_entry(KIND_SPEED, tgt, 1'b0);
               cnt = cnt + 2'd1;
            end
            plan.entries[cnt] = make_entry(KIND_CLEAR, tgt, 1'b0);
            cnt = cnt + 2'd1;
            plan.near_time = accum_ff;
            held_in = 1'b0;
            accum_in = '0;
            speed_in = tgt;
         end
      end else begin
         // Clear: build up near time, declare the obstacle once confirmed.
         if (near) begin
            accum_in = accum_sum;
         end
         if (near && (accum_sum >= confirm_ff)) begin
            held_in = 1'b1;
            if (speed_ff > SPEED_ZERO) begin
               since_in = '0;
               speed_in = SPEED_ZERO;
               if (since_sum >= pause_ff) begin
                  plan.entries[cnt] = make_entry(KIND_SPEED, SPEED_MIN, 1'b1);
                  cnt = cnt + 2'd1;
               end
               plan.entries[cnt] = make_entry(KIND_SPEED, SPEED_ZERO, 1'b0);
               cnt = cnt + 2'd1;
            end
            plan.entries[cnt] = make_entry(KIND_DETECT, speed_in, 1'b0);
            cnt = cnt + 2'd1;
         end else if (speed_ff != tgt) begin
            plan.entries[cnt] = make_entry(KIND_SPEED, tgt, 1'b0);
            cnt = cnt + 2'd1;
            speed_in = tgt;
         end
      end
      plan.count = cnt;
   end

   assign plan_push = accept && (cnt != 2'd0);

   // Controller state advances on every accepted tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= SPEED_ZERO;
         held_ff <= 1'b0;
         accum_ff <= '0;
         rep_ff <= '0;
         since_ff <= '0;
      end else if (accept) begin
         speed_ff <= speed_in;
         held_ff <= held_in;
         accum_ff <= accum_in;
         rep_ff <= rep_in;
         since_ff <= since_in;
      end
   end

endmodule

`default_nettype wire

// File: design/osmd_queue.sv
// Short queue of tick plans between the front and back parts.
// Register-based ring buffer; uses plan_type from osmd_pkg.
`default_nettype none

module osmd_queue
   import osmd_pkg::*;
#(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire plan_type push_plan,
   output logic          full,
   input  wire logic     pop,
   output logic          not_empty,
   output plan_type      head_plan
);

   localparam int unsigned PtrW = $clog2(DEPTH);
   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

   plan_type           store_ff [DEPTH];
   logic [PtrW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic               do_push, do_pop;

   assign full = (count_ff == CntW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_plan = store_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop = pop && not_empty;

   // Pointer and fill count updates.
   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == LastPtr) ? '0 : wr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == LastPtr) ? '0 : rd_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   // Plan storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ff] <= push_plan;
      end
   end

endmodule

`default_nettype wire

// File: design/osmd_back.sv
// Back part: walks the head plan into the output register one result per cycle
// while it is empty or popped; PWM levels from a constant table; uses osmd_pkg.
`default_nettype none

module osmd_back
   import osmd_pkg::*;
#(
   parameter int unsigned DRIVE_MAX = 1023
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         plan_valid,
   input  wire plan_type     plan,
   output logic              plan_pop,
   input  wire logic         rsp_pop,
   output logic              rsp_empty,
   output kind_type          rsp_kind,
   output logic signed [7:0] rsp_motor_speed,
   output logic signed [7:0] rsp_target_echo,
   output logic [9:0]        rsp_drive_a,
   output logic [9:0]        rsp_drive_b,
   output logic [9:0]        rsp_hold_ms,
   output logic [8:0]        rsp_event_distance,
   output logic [15:0]       rsp_near_time,
   output logic              rsp_last
);

   localparam int unsigned MagW = 7;
   localparam int unsigned MagCount = 1 << MagW;
   localparam logic [9:0] DriveFull = 10'(DRIVE_MAX);

   // Drive level left on the active pin for each speed magnitude.
   logic [9:0] pwm_tab [MagCount];
   for (genvar g = 0; g < MagCount; g++) begin : g_pwm
      localparam int unsigned Lvl = (g * DRIVE_MAX) / 100;
      assign pwm_tab[g] = 10'(DRIVE_MAX - Lvl);
   end

   logic [1:0]        idx_ff, idx_in;
   logic              valid_ff;
   logic              load, is_last;
   entry_type         ent;
   logic [MagW-1:0]   mag;
   logic signed [7:0] neg_speed;

   kind_type          kind_ff;
   logic signed [7:0] speed_ff, target_ff;
   logic [9:0]        drive_a_ff, drive_b_ff, hold_ff;
   logic [8:0]        dist_ff;
   logic [15:0]       ntime_ff;
   logic              last_ff;

   assign load = plan_valid && (!valid_ff || rsp_pop);
   assign ent = plan.entries[idx_ff];
   assign is_last = (idx_ff + 2'd1 == plan.count);
   assign plan_pop = load && is_last;
   assign idx_in = is_last ? 2'd0 : idx_ff + 2'd1;
   assign neg_speed = -ent.speed;
   assign mag = (ent.speed < SPEED_ZERO) ? neg_speed[MagW-1:0] : ent.speed[MagW-1:0];

   // Output handshake and position within the head plan.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff <= idx_in;
      end else if (rsp_pop) begin
         valid_ff <= 1'b0;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= ent.kind;
         speed_ff <= ent.speed;
         target_ff <= plan.target;
         drive_a_ff <= (ent.speed < SPEED_ZERO) ? pwm_tab[mag] : DriveFull;
         drive_b_ff <= (ent.speed > SPEED_ZERO) ? pwm_tab[mag] : DriveFull;
         hold_ff <= ent.hold ? plan.hold_ms : '0;
         dist_ff <= (ent.kind == KIND_DIST || ent.kind == KIND_DETECT) ? plan.distance : '0;
         ntime_ff <= (ent.kind == KIND_CLEAR) ? plan.near_time : '0;
         last_ff <= is_last;
      end
   end

   assign rsp_empty = !valid_ff;
   assign rsp_kind = kind_ff;
   assign rsp_motor_speed = speed_ff;
   assign rsp_target_echo = target_ff;
   assign rsp_drive_a = drive_a_ff;
   assign rsp_drive_b = drive_b_ff;
   assign rsp_hold_ms = hold_ff;
   assign rsp_event_distance = dist_ff;
   assign rsp_near_time = ntime_ff;
   assign rsp_last = last_ff;

endmodule

`default_nettype wire

// File: design/obstacle_stop_motor_drive_core.sv
// Obstacle-stop motor drive core: top level joining front, plan queue and back.
// Depends on osmd_pkg, osmd_front, osmd_queue and osmd_back.
`default_nettype none

// Each pushed item is one control tick. The front stage classifies it in the
// cycle it is accepted and stores a plan of one to three results in a
// QUEUE_DEPTH-entry queue; a tick that changes nothing stores nothing. A new
// tick is taken every cycle while the queue has room. The back stage emits one
// result per cycle while results are popped, and the first result of a tick
// passes through the queue storage and the output register before it appears
// on the result ports. The output register lets the front keep accepting
// while a result waits to be popped. rsp_last marks the final result of each
// tick.
module obstacle_stop_motor_drive_core
   import osmd_pkg::*;
#(
   parameter int unsigned DRIVE_MAX = 1023,
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic [9:0]        req_delta_ms,
   input  wire logic [8:0]        req_distance,
   input  wire logic signed [7:0] req_target_speed,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output logic [1:0]             rsp_kind,
   output logic signed [7:0]      rsp_motor_speed,
   output logic signed [7:0]      rsp_target_echo,
   output logic [9:0]             rsp_drive_a,
   output logic [9:0]             rsp_drive_b,
   output logic [9:0]             rsp_hold_ms,
   output logic [8:0]             rsp_event_distance,
   output logic [15:0]            rsp_near_time,
   output logic                   rsp_last,
   input  wire logic              csr_write_en,
   input  wire logic [2:0]        csr_index,
   input  wire logic [15:0]       csr_wdata
);

   logic     accept;
   logic     plan_push, plan_pop, plan_valid;
   plan_type front_plan, head_plan;
   kind_type kind;

   assign accept = req_push && !req_full;
   assign rsp_kind = kind;

   // Classification of incoming ticks.
   osmd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .delta_ms     (req_delta_ms),
      .distance     (req_distance),
      .target_speed (req_target_speed),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .plan_push    (plan_push),
      .plan         (front_plan)
   );

   // Plans waiting for the back stage.
   osmd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (plan_push),
      .push_plan (front_plan),
      .full      (req_full),
      .pop       (plan_pop),
      .not_empty (plan_valid),
      .head_plan (head_plan)
   );

   // Result emission.
   osmd_back #(
      .DRIVE_MAX (DRIVE_MAX)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .plan_valid         (plan_valid),
      .plan               (head_plan),
      .plan_pop           (plan_pop),
      .rsp_pop            (rsp_pop),
      .rsp_empty          (rsp_empty),
      .rsp_kind           (kind),
      .rsp_motor_speed    (rsp_motor_speed),
      .rsp_target_echo    (rsp_target_echo),
      .rsp_drive_a        (rsp_drive_a),
      .rsp_drive_b        (rsp_drive_b),
      .rsp_hold_ms        (rsp_hold_ms),
      .rsp_event_distance (rsp_event_distance),
      .rsp_near_time      (rsp_near_time),
      .rsp_last           (rsp_last)
   );

`ifndef SYNTHESIS
   // Only the full-reverse brake result carries a hold time.
   a_hold_on_brake: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_hold_ms != 10'd0) |->
         (rsp_motor_speed == SPEED_MIN && kind == KIND_SPEED))
      else $error("hold time on a result that is not a reverse brake");

   // A stopped motor drives both pins to the same level.
   a_stop_levels: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_motor_speed == SPEED_ZERO) |-> (rsp_drive_a == rsp_drive_b))
      else $error("unequal drive levels at zero speed");

   // A clear result carries neither a distance nor a hold time.
   a_clear_fields: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && kind == KIND_CLEAR) |->
         (rsp_event_distance == 9'd0 && rsp_hold_ms == 10'd0))
      else $error("clear result with distance or hold time");
`endif

endmodule

`default_nettype wire

// File: sim/tb_obstacle_stop_motor_drive_core.sv
// Self-checking testbench for obstacle_stop_motor_drive_core: directed table, saturation,
// back-pressure and randomized obstacle episodes, all checked against a built-in predictor.
// Depends on osmd_pkg and the obstacle_stop_motor_drive_core RTL.
module tb_obstacle_stop_motor_drive_core
   import osmd_pkg::*;
;

   localparam int DRIVE_LEVEL = 1023;
   localparam int IDLE_SETTLE = 8;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int CYCLE_LIMIT = 500000;
   localparam int SATURATION_TICKS = 66;
   localparam int PRESSURE_TICKS = 40;
   localparam int RANDOM_PHASES = 6;
   localparam int TICKS_PER_PHASE = 60;

   // Register indexes past the end of the map; writes to them must be ignored.
   localparam logic [2:0] REG_SPARE_A = 3'd6;
   localparam logic [2:0] REG_SPARE_B = 3'd7;

   // One result item as it appears on the rsp_ ports.
   typedef struct packed {
      kind_type          kind;
      logic signed [7:0] motor_speed;
      logic signed [7:0] target_echo;
      logic [9:0]        drive_a;
      logic [9:0]        drive_b;
      logic [9:0]        hold_ms;
      logic [8:0]        event_distance;
      logic [15:0]       near_time;
      logic              last;
   } tick_result_type;

   // One control tick, optionally with its single result typed in by hand.
   typedef struct packed {
      logic [9:0]        delta;
      logic [8:0]        distance;
      logic signed [7:0] target;
      logic              typed;
      logic              has_result;
      tick_result_type   result;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic [9:0] req_delta_ms = '0;
   logic [8:0] req_distance = '0;
   logic signed [7:0] req_target_speed = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [1:0] rsp_kind;
   logic signed [7:0] rsp_motor_speed;
   logic signed [7:0] rsp_target_echo;
   logic [9:0] rsp_drive_a;
   logic [9:0] rsp_drive_b;
   logic [9:0] rsp_hold_ms;
   logic [8:0] rsp_event_distance;
   logic [15:0] rsp_near_time;
   logic rsp_last;
   logic csr_write_en = 1'b0;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // Predictor copy of the configuration and the controller state.
   logic [8:0] thr_detect, thr_clear, step_cfg;
   logic [9:0] hold_cfg;
   logic [15:0] confirm_cfg, pause_cfg;
   logic signed [7:0] cur_speed;
   logic obstacle_on;
   logic [15:0] near_ms;
   logic [8:0] last_reported;
   logic [15:0] ms_since_brake;

   tick_result_type tick_results[$];
   tick_result_type pending_results[$];
   stim_row_type directed_rows[$];

   int fail_count = 0;
   int ticks_sent = 0;
   int results_checked = 0;
   int settings_used = 0;
   int cycle_count = 0;
   int hold_off_req = 0;
   int hold_off_done = 0;
   int pop_idle = 0;
   logic steady = 1'b0;

   obstacle_stop_motor_drive_core #(.DRIVE_MAX(DRIVE_LEVEL)) u_dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_delta_ms(req_delta_ms),
      .req_distance(req_distance),
      .req_target_speed(req_target_speed),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_kind(rsp_kind),
      .rsp_motor_speed(rsp_motor_speed),
      .rsp_target_echo(rsp_target_echo),
      .rsp_drive_a(rsp_drive_a),
      .rsp_drive_b(rsp_drive_b),
      .rsp_hold_ms(rsp_hold_ms),
      .rsp_event_distance(rsp_event_distance),
      .rsp_near_time(rsp_near_time),
      .rsp_last(rsp_last),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Free-running clock, period 8.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Idle gap length: mostly none, sometimes short, rarely long.
   function automatic int pick_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [15:0] sat_add(input logic [15:0] acc, input logic [9:0] inc);
      logic [16:0] sum;
      sum = {1'b0, acc} + 17'(inc);
      return sum[16] ? 16'hFFFF : sum[15:0];
   endfunction

   // Append one result, with PWM levels taken from the current speed.
   function automatic void emit_result(input kind_type kind, input logic signed [7:0] tgt,
                                      input logic [9:0] hold, input logic [8:0] ev_dist,
                                      input logic [15:0] ntime);
      tick_result_type r;
      int mag, pwm;
      mag = (cur_speed < 0) ? -int'(cur_speed) : int'(cur_speed);
      pwm = mag * DRIVE_LEVEL / 100;
      r.kind = kind;
      r.motor_speed = cur_speed;
      r.target_echo = tgt;
      r.drive_a = 10'(DRIVE_LEVEL);
      r.drive_b = 10'(DRIVE_LEVEL);
      if (cur_speed > 0) r.drive_b = 10'(DRIVE_LEVEL - pwm);
      else if (cur_speed < 0) r.drive_a = 10'(DRIVE_LEVEL - pwm);
      r.hold_ms = hold;
      r.event_distance = ev_dist;
      r.near_time = ntime;
      r.last = 1'b0;
      tick_results.push_back(r);
   endfunction

   function automatic void change_speed(input logic signed [7:0] s,
                                        input logic signed [7:0] tgt, input logic [9:0] hold);
      if (s == cur_speed) return;
      cur_speed = s;
      emit_result(KIND_SPEED, tgt, hold, 9'd0, 16'd0);
   endfunction

   // Work out every result one tick causes and update the predictor state.
   function automatic void predict_tick(input logic [9:0] delta,
                                        input logic [8:0] distance_now,
                                        input logic signed [7:0] raw);
      logic signed [7:0] tgt;
      logic [8:0] diff;
      logic near;
      tick_result_type tail;
      tick_results.delete();
      tgt = raw;
      if (raw > SPEED_MAX) tgt = SPEED_MAX;
      else if (raw < SPEED_MIN) tgt = SPEED_MIN;
      ms_since_brake = sat_add(ms_since_brake, delta);
      near = obstacle_on ? (distance_now < thr_clear) : (distance_now < thr_detect);
      diff = (distance_now >= last_reported) ? distance_now - last_reported
                                             : last_reported - distance_now;
      // Distance report while an obstacle is held.
      if (obstacle_on && diff >= step_cfg) begin
         emit_result(KIND_DIST, tgt, 10'd0, distance_now, 16'd0);
         last_reported = distance_now;
      end
      // Detection with brake, or clearing.
      if (near) begin
         near_ms = sat_add(near_ms, delta);
         if (near_ms >= confirm_cfg && !obstacle_on) begin
            obstacle_on = 1'b1;
            if (cur_speed > 0) begin
               if (ms_since_brake < pause_cfg) begin
                  change_speed(SPEED_ZERO, tgt, 10'd0);
               end else begin
                  change_speed(SPEED_MIN, tgt, hold_cfg);
                  change_speed(SPEED_ZERO, tgt, 10'd0);
               end
               ms_since_brake = '0;
            end
            emit_result(KIND_DETECT, tgt, 10'd0, distance_now, 16'd0);
         end
      end else if (obstacle_on) begin
         change_speed(tgt, tgt, 10'd0);
         emit_result(KIND_CLEAR, tgt, 10'd0, 9'd0, near_ms);
         obstacle_on = 1'b0;
         near_ms = '0;
      end
      // Speed tracking while clear.
      if (!obstacle_on) change_speed(tgt, tgt, 10'd0);
      if (tick_results.size() > 0) begin
         tail = tick_results.pop_back();
         tail.last = 1'b1;
         tick_results.push_back(tail);
      end
   endfunction

   function automatic stim_row_type plain_row(input logic [9:0] delta, input logic [8:0] dist_v,
                                              input logic signed [7:0] tgt);
      stim_row_type row;
      row = '0;
      row.delta = delta;
      row.distance = dist_v;
      row.target = tgt;
      return row;
   endfunction

   // A tick known to cause no result.
   function automatic stim_row_type quiet_row(input logic [9:0] delta, input logic [8:0] dist_v,
                                              input logic signed [7:0] tgt);
      stim_row_type row;
      row = plain_row(delta, dist_v, tgt);
      row.typed = 1'b1;
      return row;
   endfunction

   // A tick known to cause exactly one result, with no hold and no near time.
   function automatic stim_row_type typed_row(input logic [9:0] delta, input logic [8:0] dist_v,
                                              input logic signed [7:0] tgt, input kind_type kind,
                                              input logic signed [7:0] speed,
                                              input logic signed [7:0] echo,
                                              input logic [9:0] lvl_a, input logic [9:0] lvl_b,
                                              input logic [8:0] ev_dist);
      stim_row_type row;
      row = quiet_row(delta, dist_v, tgt);
      row.has_result = 1'b1;
      row.result = '{kind, speed, echo, lvl_a, lvl_b, 10'd0, ev_dist, 16'd0, 1'b1};
      return row;
   endfunction

   function automatic void check_field(input string name, input logic signed [31:0] want,
                                       input logic signed [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // Offer one tick, wait until it is taken, then queue what it should cause.
   task automatic send_tick(input stim_row_type row);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_delta_ms <= row.delta;
      req_distance <= row.distance;
      req_target_speed <= row.target;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_tick(row.delta, row.distance, row.target);
      if (row.typed) begin
         if (tick_results.size() != int'(row.has_result) ||
             (row.has_result && tick_results[0] != row.result)) begin
            $error("directed row %0d disagrees with the predictor", ticks_sent);
            fail_count++;
         end
         if (row.has_result) pending_results.push_back(row.result);
      end else begin
         foreach (tick_results[i]) pending_results.push_back(tick_results[i]);
      end
      ticks_sent++;
      @(negedge clock);
   endtask

   // Stop offering, wait for every expected item, then let the pipeline settle.
   task automatic wait_idle();
      req_push <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (IDLE_SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_DETECT_DISTANCE: thr_detect = val[8:0];
         REG_CLEAR_DISTANCE:  thr_clear = val[8:0];
         REG_BRAKE_HOLD_MS:   hold_cfg = val[9:0];
         REG_REPORT_STEP:     step_cfg = val[8:0];
         REG_CONFIRM_MS:      confirm_cfg = val;
         REG_BRAKE_PAUSE_MS:  pause_cfg = val;
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   // Program all six registers; unused upper data bits carry random junk.
   task automatic write_all(input logic [8:0] det, input logic [8:0] clr,
                            input logic [9:0] hold, input logic [8:0] step,
                            input logic [15:0] conf, input logic [15:0] pause);
      write_reg(REG_DETECT_DISTANCE, {7'($urandom), det});
      write_reg(REG_CLEAR_DISTANCE, {7'($urandom), clr});
      write_reg(REG_BRAKE_HOLD_MS, {6'($urandom), hold});
      write_reg(REG_REPORT_STEP, {7'($urandom), step});
      write_reg(REG_CONFIRM_MS, conf);
      write_reg(REG_BRAKE_PAUSE_MS, pause);
      settings_used++;
   endtask

   // Result side: pop with random gaps, plus one long hold-off on request.
   always @(negedge clock) begin
      if (pop_idle > 0) begin
         rsp_pop <= 1'b0;
         pop_idle--;
      end else if (hold_off_req != hold_off_done) begin
         rsp_pop <= 1'b0;
         pop_idle = HOLD_OFF_CYCLES;
         hold_off_done++;
      end else begin
         rsp_pop <= 1'b1;
         pop_idle = pick_gap();
      end
   end

   // Compare each popped item with the oldest expectation.
   always @(posedge clock) begin : check_results
      tick_result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_results.size() == 0) begin
            $error("result with nothing expected: kind %0d, speed %0d", rsp_kind,
                   rsp_motor_speed);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("kind", want.kind, rsp_kind);
            check_field("motor_speed", want.motor_speed, rsp_motor_speed);
            check_field("target_echo", want.target_echo, rsp_target_echo);
            check_field("drive_a", want.drive_a, rsp_drive_a);
            check_field("drive_b", want.drive_b, rsp_drive_b);
            check_field("hold_ms", want.hold_ms, rsp_hold_ms);
            check_field("event_distance", want.event_distance, rsp_event_distance);
            check_field("near_time", want.near_time, rsp_near_time);
            check_field("last", want.last, rsp_last);
         end
         results_checked++;
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      stim_row_type row;
      int ep_left, ep_len, ep_dist, ep_fall, ep_target;
      int det, clr;

      // Predictor starts from the reset state.
      thr_detect = RST_DETECT_DISTANCE;
      thr_clear = RST_CLEAR_DISTANCE;
      hold_cfg = RST_BRAKE_HOLD_MS;
      step_cfg = RST_REPORT_STEP;
      confirm_cfg = RST_CONFIRM_MS;
      pause_cfg = RST_BRAKE_PAUSE_MS;
      cur_speed = SPEED_ZERO;
      obstacle_on = 1'b0;
      near_ms = '0;
      last_reported = '0;
      ms_since_brake = '0;
      ep_left = 0;
      ep_len = 1;
      ep_dist = 511;
      ep_fall = 10;
      ep_target = 50;

      // Directed table, run with the reset configuration.
      directed_rows.push_back(quiet_row(10'd0, 9'd511, 8'sd0));
      directed_rows.push_back(typed_row(10'd0, 9'd511, 8'sd127, KIND_SPEED, 8'sd100, 8'sd100,
                                        10'd1023, 10'd0, 9'd0));
      directed_rows.push_back(typed_row(10'd1023, 9'd511, -8'sd128, KIND_SPEED, -8'sd100,
                                        -8'sd100, 10'd0, 10'd1023, 9'd0));
      directed_rows.push_back(typed_row(10'd0, 9'd511, 8'sd100, KIND_SPEED, 8'sd100, 8'sd100,
                                        10'd1023, 10'd0, 9'd0));
      // Near time builds up across separate near readings while clear.
      directed_rows.push_back(quiet_row(10'd50, 9'd0, 8'sd100));
      directed_rows.push_back(quiet_row(10'd20, 9'd511, 8'sd100));
      // Detection at speed with a full-reverse brake.
      directed_rows.push_back(plain_row(10'd60, 9'd100, 8'sd100));
      directed_rows.push_back(typed_row(10'd5, 9'd140, 8'sd50, KIND_DIST, 8'sd0, 8'sd50,
                                        10'd1023, 10'd1023, 9'd140));
      directed_rows.push_back(quiet_row(10'd5, 9'd150, 8'sd50));
      directed_rows.push_back(plain_row(10'd5, 9'd176, 8'sd50));
      directed_rows.push_back(quiet_row(10'd0, 9'd511, 8'sd50));
      // Brake too soon after the last one gives a plain stop.
      directed_rows.push_back(plain_row(10'd100, 9'd10, 8'sd50));
      directed_rows.push_back(plain_row(10'd1023, 9'd511, -8'sd20));
      // Detection while reversing does not brake.
      directed_rows.push_back(typed_row(10'd200, 9'd0, -8'sd20, KIND_DETECT, -8'sd20, -8'sd20,
                                        10'd819, 10'd1023, 9'd0));
      directed_rows.push_back(plain_row(10'd7, 9'd60, -8'sd20));
      directed_rows.push_back(plain_row(10'd0, 9'd500, -8'sd5));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) send_tick(directed_rows[i]);
      wait_idle();

      // Saturation of near time and time since brake, with top register values.
      // Writes to the spare indexes would zero a register if they were not ignored.
      steady = 1'b1;
      write_all(9'd511, 9'd511, 10'd1023, 9'd0, 16'hFFFF, 16'hFFFF);
      write_reg(REG_SPARE_A, 16'h0000);
      write_reg(REG_SPARE_B, 16'h0000);
      steady = 1'b0;
      repeat (SATURATION_TICKS) send_tick(plain_row(10'd1023, 9'd0, 8'sd100));
      send_tick(plain_row(10'd1, 9'd511, 8'sd100));
      wait_idle();

      // Back-pressure: every tick changes speed while the result side holds off.
      write_all(9'd0, 9'd0, 10'd0, 9'd0, 16'd0, 16'd0);
      steady = 1'b1;
      hold_off_req++;
      for (int i = 0; i < PRESSURE_TICKS; i++) begin
         send_tick(plain_row(10'($urandom_range(0, 3)), 9'($urandom),
                             (i % 2 == 0) ? 8'($urandom_range(1, 100))
                                          : -8'($urandom_range(0, 100))));
      end
      wait_idle();

      // Random phases: approach-and-retreat episodes mixed with noise ticks.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0) begin
            write_all(RST_DETECT_DISTANCE, RST_CLEAR_DISTANCE, RST_BRAKE_HOLD_MS,
                      RST_REPORT_STEP, RST_CONFIRM_MS, RST_BRAKE_PAUSE_MS);
         end else if (phase == 1) begin
            write_all(9'd511, 9'd511, 10'd1023, 9'd511, 16'd0, 16'd0);
         end else begin
            det = $urandom_range(40, 400);
            clr = det + $urandom_range(0, 60);
            if (clr > 511) clr = 511;
            write_all(9'(det), 9'(clr), 10'($urandom_range(0, 1023)),
                      9'($urandom_range(0, 64)), 16'($urandom_range(0, 300)),
                      16'($urandom_range(0, 1500)));
         end
         for (int i = 0; i < TICKS_PER_PHASE; i++) begin
            if (i % 20 == 0) steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0) begin
               row = plain_row(($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 40))
                                                           : 10'($urandom),
                               9'($urandom), 8'($urandom));
            end else begin
               // Start a new episode: far away, closing in, then backing off.
               if (ep_left == 0) begin
                  ep_len = $urandom_range(6, 30);
                  ep_left = ep_len;
                  ep_dist = $urandom_range(150, 511);
                  ep_fall = $urandom_range(5, 40);
                  ep_target = ($urandom_range(0, 9) < 7) ? int'($urandom_range(1, 100))
                                                         : -int'($urandom_range(0, 100));
               end
               if ($urandom_range(0, 9) == 0) ep_target = int'($urandom_range(0, 200)) - 100;
               if (ep_left * 2 > ep_len) ep_dist = ep_dist - ep_fall;
               else ep_dist = ep_dist + ep_fall;
               if (ep_dist < 0) ep_dist = 0;
               if (ep_dist > 511) ep_dist = 511;
               ep_left--;
               row = plain_row(10'($urandom_range(0, 40)), 9'(ep_dist), 8'(ep_target));
            end
            send_tick(row);
         end
         wait_idle();
      end

      $display("Sent %0d ticks over %0d register settings and checked %0d result items,",
               ticks_sent, settings_used, results_checked);
      $display("covering brakes, plain stops, clears, distance reports and saturation.");
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// File: obstacle_stop_motor_drive_core.f
design/osmd_pkg.sv
design/osmd_front.sv
design/osmd_queue.sv
design/osmd_back.sv
design/obstacle_stop_motor_drive_core.sv
sim/tb_obstacle_stop_motor_drive_core.sv
